@@ hdl/cers_pkg.sv @@
package cers_pkg;

  localparam int VERTEX_W = 14;
  localparam int NUM_W    = 12;
  localparam int MAG_W    = 11;
  localparam int STATUS_W = 3;
  localparam int SLOTS    = 4;
  localparam int LONGS    = 2;
  localparam int CANDS    = SLOTS + LONGS;

  typedef logic [VERTEX_W-1:0] vertex_t;

  // one edge record: two long words above four short slots
  typedef struct packed {
    vertex_t                lw1;
    vertex_t                lw0;
    logic [SLOTS-1:0][VERTEX_W-1:0] slot;
  } edge_rec_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED_SHORT = 3'd0,
    ST_STORED_LONG  = 3'd1,
    ST_OVERFLOW     = 3'd2,
    ST_LISTED       = 3'd3,
    ST_NO_EDGES     = 3'd4
  } status_t;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_LIST = 1'b1
  } op_t;

  // short code back to a full neighbour id, relative to the owner's numeric id
  function automatic vertex_t decode_slot(input logic [NUM_W-1:0] own_num,
                                          input vertex_t raw);
    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] num;
    begin
      mag = {1'b0, raw[MAG_W+1:2]};
      num = raw[VERTEX_W-1] ? (own_num + mag) : (own_num - mag);
      decode_slot = {num, raw[1:0]};
    end
  endfunction

endpackage

@@ hdl/compact_edge_record_store.sv @@
// compact edge record store: one 84-bit edge record per vertex, held in a
// synchronous memory of 2^13 records with one read and one write port (node
// and pin halves picked by bit 0 of the vertex id). after reset the block
// sweeps the memory to zero, one record a cycle, and keeps busy high for the
// whole sweep. for an add, the accept edge reads the record and the next
// cycle picks the slot, writes the record back and registers the single
// result. a list reads the record and de-duplicates it in the same steps,
// then shows one result per distinct neighbour on consecutive cycles (up to
// six); an empty record gives a single no-edges result instead. busy stays
// high until the last result of an item is on the ports; results carry a
// one-cycle out_valid strobe and cannot be held off by the receiver.
module compact_edge_record_store
  import cers_pkg::*;
#(
  parameter int ID_BITS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_operation,
  input  logic [VERTEX_W-1:0] in_self_vertex,
  input  logic [VERTEX_W-1:0] in_other_vertex,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [VERTEX_W-1:0] out_edge_vertex,
  output logic                out_last
);

  // only the numeric id bits that fit in a vertex id reach the record index
  localparam int IDX_NUM_W = (ID_BITS < NUM_W) ? ID_BITS : NUM_W;
  localparam int ADDR_W    = IDX_NUM_W + 1;
  localparam int DEPTH     = 1 << ADDR_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_EMIT
  } state_t;

  state_t                state_r;
  logic [ADDR_W-1:0]     clr_cnt_r;
  logic                  op_r;
  vertex_t               self_r;
  vertex_t               other_r;
  edge_rec_t             rd_data_r;
  logic [CANDS-1:0]      keep_r;
  vertex_t               list_r [CANDS];
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  vertex_t               out_vertex_r;
  logic                  out_last_r;

  // record memory
  edge_rec_t             mem [DEPTH];
  logic [ADDR_W-1:0]     rd_addr;
  logic [ADDR_W-1:0]     self_addr;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  edge_rec_t             wr_data;

  // add path
  logic [NUM_W-1:0]      own_num;
  logic [NUM_W-1:0]      oth_num;
  logic                  neg;
  logic [NUM_W-1:0]      mag;
  logic                  fits;
  vertex_t               code;
  logic                  short_found;
  logic [1:0]            short_idx;
  logic                  long_found;
  logic                  long_idx;
  edge_rec_t             upd_rec;
  status_t               add_status;

  // list path
  vertex_t               cand [CANDS];
  logic [CANDS-1:0]      keep;

  // emit selection
  logic [2:0]            sel_idx;
  logic [CANDS-1:0]      keep_left;

  // record index: numeric id with the pin bit below it, driver bit dropped
  assign rd_addr   = {in_self_vertex[IDX_NUM_W+1:2], in_self_vertex[0]};
  assign self_addr = {self_r[IDX_NUM_W+1:2], self_r[0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // add: first empty short slot if the distance fits, else first empty long word
  always_comb begin
    own_num = self_r[VERTEX_W-1:2];
    oth_num = other_r[VERTEX_W-1:2];
    neg     = own_num < oth_num;
    mag     = neg ? (oth_num - own_num) : (own_num - oth_num);
    fits    = ~mag[NUM_W-1];
    code    = {neg, mag[MAG_W-1:0], other_r[1:0]};

    short_found = 1'b0;
    short_idx   = 2'd0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (rd_data_r.slot[i] == '0) begin
        short_found = 1'b1;
        short_idx   = 2'(i);
      end
    end
    long_found = (rd_data_r.lw0 == '0) || (rd_data_r.lw1 == '0);
    long_idx   = (rd_data_r.lw0 != '0);

    upd_rec = rd_data_r;
    if (fits && short_found) begin
      upd_rec.slot[short_idx] = code;
      add_status = ST_STORED_SHORT;
    end else if (long_found) begin
      if (long_idx) begin
        upd_rec.lw1 = other_r;
      end else begin
        upd_rec.lw0 = other_r;
      end
      add_status = ST_STORED_LONG;
    end else begin
      add_status = ST_OVERFLOW;
    end
  end

  // list: decode all six places, keep the first of each distinct neighbour
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cand[i] = decode_slot(self_r[VERTEX_W-1:2], rd_data_r.slot[i]);
    end
    cand[SLOTS]     = rd_data_r.lw0;
    cand[SLOTS + 1] = rd_data_r.lw1;
    for (int i = 0; i < CANDS; i++) begin
      if (i < SLOTS) begin
        keep[i] = (rd_data_r.slot[i] != '0);
      end else begin
        keep[i] = (cand[i] != '0);
      end
    end
    for (int i = 1; i < CANDS; i++) begin
      for (int j = 0; j < i; j++) begin
        if (keep[j] && cand[j] == cand[i]) begin
          keep[i] = 1'b0;
        end
      end
    end
  end

  // next neighbour to show: lowest remaining place
  always_comb begin
    sel_idx = 3'd0;
    for (int i = CANDS - 1; i >= 0; i--) begin
      if (keep_r[i]) begin
        sel_idx = 3'(i);
      end
    end
    keep_left          = keep_r;
    keep_left[sel_idx] = 1'b0;
  end

  // single write port: clearing sweep or write-back of an add
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = self_addr;
    wr_data = upd_rec;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
      end
      S_EVAL: begin
        wr_en = (op_r == OP_ADD) && (add_status != ST_OVERFLOW);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      keep_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          // the accept edge also launches the record read
          if (start) begin
            op_r    <= in_operation;
            self_r  <= in_self_vertex;
            other_r <= in_other_vertex;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (op_r == OP_ADD) begin
            out_valid_r  <= 1'b1;
            out_status_r <= add_status;
            out_vertex_r <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end else if (keep == '0) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_NO_EDGES;
            out_vertex_r <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            keep_r <= keep;
            for (int i = 0; i < CANDS; i++) begin
              list_r[i] <= cand[i];
            end
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_valid_r  <= 1'b1;
          out_status_r <= ST_LISTED;
          out_vertex_r <= list_r[sel_idx];
          out_last_r   <= (keep_left == '0);
          keep_r       <= keep_left;
          if (keep_left == '0) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_edge_vertex = out_vertex_r;
  assign out_last        = out_last_r;

`ifndef ASSERT_OFF
  // an accepted item keeps the block busy for its evaluation cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepting an item");

  // the results of a listing come on back-to-back cycles
  a_list_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && out_status == ST_LISTED)
    else $error("listing burst broken");

  // no result directly follows the final one
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result right after the final one");

  // only listed neighbours may be followed by more results
  a_single_add: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_LISTED |-> out_last)
    else $error("non-listing result without last");

  // no memory write while the block waits for an item
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !wr_en)
    else $error("record written while idle");
`endif

endmodule
